// ----- hw/rtl/pidaw_pkg.sv -----
// shared types, constants and saturation helper for the pi controller core
package pidaw_pkg;

    localparam int MEAS_W    = 24;
    localparam int ERR_W     = 25;
    localparam int GAIN_W    = 24;
    localparam int DB_W      = 23;
    localparam int TERM_W    = 32;
    localparam int DRIVE_W   = 8;
    localparam int WIDE_W    = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 136;

    // largest drive code, a fixed constant of this core
    localparam int DRIVE_MAX = 255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND    = 2'd0,
        CFG_DB_ENABLE   = 2'd1,
        CFG_KP          = 2'd2,
        CFG_KI          = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic              deadband_enable;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
    } cfg_t;

    typedef struct packed {
        logic signed [MEAS_W-1:0] measured;
        logic signed [MEAS_W-1:0] target;
        logic signed [MEAS_W-1:0] feedforward;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]       drive;
        logic                     saturated;
        logic signed [ERR_W-1:0]  error_out;
        logic signed [TERM_W-1:0] p_term;
        logic signed [TERM_W-1:0] i_term;
        logic signed [TERM_W-1:0] feedback;
    } result_t;

    // symmetric clamp to +/- (2^31 - 1)
    function automatic logic signed [TERM_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lim;
        lim = WIDE_W'(64'sd2147483647);
        if (v > lim) begin
            return lim[TERM_W-1:0];
        end else if (v < -lim) begin
            return -lim[TERM_W-1:0];
        end else begin
            return v[TERM_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/pidaw_calc.sv -----
// pi step datapath: deadband, p and i terms, drive clamp, and the loop state
module pidaw_calc import pidaw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  cfg_t     cfg,
    input  in_item_t item,
    output result_t  res
);

    logic signed [TERM_W-1:0] integral_reg;
    logic signed [TERM_W-1:0] integral_next;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic                     was_sat_reg;

    logic signed [ERR_W-1:0]    err_raw;
    logic signed [ERR_W:0]      err_w;
    logic signed [ERR_W:0]      db_s;
    logic                       in_band;
    logic signed [ERR_W-1:0]    err;
    logic signed [2*ERR_W-1:0]  p_prod;
    logic signed [ERR_W:0]      err_sum;
    logic signed [2*ERR_W:0]    i_prod;
    logic signed [WIDE_W-1:0]   i_sum;
    logic signed [TERM_W-1:0]   p_term;
    logic signed [TERM_W-1:0]   i_term;
    logic signed [TERM_W-1:0]   fb;
    logic signed [TERM_W+1:0]   u_sum;
    logic signed [TERM_W-7:0]   u_int;
    logic                       over;
    logic                       sat;
    logic [DRIVE_W-1:0]         drive;

    always_comb begin
        err_raw = {item.target[MEAS_W-1], item.target}
                - {item.measured[MEAS_W-1], item.measured};
        err_w   = {err_raw[ERR_W-1], err_raw};
        db_s    = $signed({3'b000, cfg.deadband});
        in_band = cfg.deadband_enable && (err_w < db_s) && (err_w > -db_s);
        err     = in_band ? '0 : err_raw;

        // gain x error is Q.24, floor back to Q.8
        p_prod  = $signed({1'b0, cfg.kp}) * err;
        p_term  = sat32(WIDE_W'($signed(p_prod[2*ERR_W-1:16])));

        err_sum = {err[ERR_W-1], err} + {prev_err_reg[ERR_W-1], prev_err_reg};
        i_prod  = $signed({1'b0, cfg.ki}) * err_sum;
        i_sum   = WIDE_W'(integral_reg) + WIDE_W'($signed(i_prod[2*ERR_W:16]));
        i_term  = sat32(i_sum);

        fb      = sat32(WIDE_W'(p_term) + WIDE_W'(i_term));

        u_sum   = (TERM_W+2)'(fb) + (TERM_W+2)'(item.feedforward);
        u_int   = u_sum[TERM_W+1:8];
        over    = u_int > $signed((TERM_W-6)'(DRIVE_MAX));

        // negative sums truncate toward zero: -255..-1 still gives zero unclamped
        if (u_sum[TERM_W+1]) begin
            sat   = u_sum <= -(TERM_W+2)'(256);
            drive = '0;
        end else if (over) begin
            sat   = 1'b1;
            drive = DRIVE_W'(DRIVE_MAX);
        end else begin
            sat   = 1'b0;
            drive = u_int[DRIVE_W-1:0];
        end

        integral_next = was_sat_reg ? '0 : i_term;

        res.drive     = drive;
        res.saturated = sat;
        res.error_out = err;
        res.p_term    = p_term;
        res.i_term    = i_term;
        res.feedback  = fb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            was_sat_reg  <= 1'b0;
        end else if (advance) begin
            integral_reg <= integral_next;
            prev_err_reg <= err;
            was_sat_reg  <= sat;
        end
    end

endmodule

// ----- hw/rtl/pi_controller_deadband_antiwindup_core.sv -----
// top level of the pi controller with deadband and anti-windup
//
//  channel   dir  handshake                 content
//  s_axis    in   s_axis_tvalid/tready      measured, target, feedforward
//  m_axis    out  m_axis_tvalid/tready      drive, saturated, error, p, i, feedback
//  cfg       in   cfg_we (no back-pressure) deadband, deadband_enable, kp, ki
//
// one word per cycle sustained while m_axis_tready holds; a word moves from the input
// register to the output register through the single combinational pass in pidaw_calc,
// and waits in the input register while the output is stalled
// the loop state (integral, previous error, saturation flag) updates as a word
// moves from the input register to the output register
// a stalled output holds its word while the input register still takes one more
// synchronous active-low reset clears valids, loop state, deadband and gains, and sets deadband_enable
module pi_controller_deadband_antiwindup_core import pidaw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [23:0] measured, [47:24] target, [71:48] feedforward
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] drive, [8] saturated, [33:9] error_out, [65:34] p_term,
    // [97:66] i_term, [129:98] feedback, [135:130] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

    cfg_t     cfg_reg;
    in_item_t in_reg;
    logic     in_valid_reg;
    result_t  out_reg;
    logic     out_valid_reg;
    result_t  res;
    logic     advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadband        <= '0;
            cfg_reg.deadband_enable <= 1'b1;
            cfg_reg.kp              <= '0;
            cfg_reg.ki              <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEADBAND:  cfg_reg.deadband        <= cfg_wdata[DB_W-1:0];
                CFG_DB_ENABLE: cfg_reg.deadband_enable <= cfg_wdata[0];
                CFG_KP:        cfg_reg.kp              <= cfg_wdata[GAIN_W-1:0];
                CFG_KI:        cfg_reg.ki              <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg.measured    <= s_axis_tdata[23:0];
            in_reg.target      <= s_axis_tdata[47:24];
            in_reg.feedforward <= s_axis_tdata[71:48];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    pidaw_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .res     (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_reg.feedback, out_reg.i_term, out_reg.p_term,
                            out_reg.error_out, out_reg.saturated, out_reg.drive};

endmodule
